@@ hdl/stw_pkg.sv @@
// shared types, constants and the segment decoder of the stopwatch controller
package stw_pkg;

    // default sizes
    localparam int DEF_NUM_DIGITS  = 4;
    localparam int DEF_NUM_RECORDS = 8;
    localparam int NUM_BUTTONS     = 4;

    // field widths
    localparam int CFG_W   = 10;
    localparam int BCD_W   = 4;
    localparam int FLASH_W = 8;
    localparam int SEL_W   = 4;
    localparam int SEG_W   = 8;
    localparam int LED_W   = 8;

    // counter and digit limits
    localparam logic [CFG_W-1:0]   COUNT_MAX     = '1;
    localparam logic [FLASH_W-1:0] FLASH_FOREVER = 8'hFF;
    localparam logic [FLASH_W-1:0] FLASH_ONCE    = 8'd1;
    localparam logic [BCD_W-1:0]   BCD_NINE      = 4'd9;
    localparam logic [SEL_W-1:0]   SELECT_BLANK  = 4'hF;
    localparam logic [SEG_W-1:0]   SEGMENTS_OFF  = 8'hFF;

    // button roles, bit i of the level word is button i+1
    localparam int BTN_RUN   = 0;
    localparam int BTN_CLEAR = 1;
    localparam int BTN_UP    = 2;
    localparam int BTN_DOWN  = 3;

    // configuration register reset values
    localparam logic [CFG_W-1:0] DEBOUNCE_RESET  = 10'd10;
    localparam logic [CFG_W-1:0] LONG_PUSH_RESET = 10'd350;
    localparam logic [CFG_W-1:0] PRESCALE_RESET  = 10'd100;
    localparam logic [CFG_W-1:0] BLINK_RESET     = 10'd500;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_DEBOUNCE  = 2'd0,
        CFG_LONG_PUSH = 2'd1,
        CFG_PRESCALE  = 2'd2,
        CFG_BLINK     = 2'd3
    } cfg_index_t;

    // operating modes
    typedef enum logic [1:0] {
        MODE_TIMING  = 2'd0,
        MODE_SETTING = 2'd1,
        MODE_VIEW    = 2'd2
    } mode_t;

    // configuration bundle
    typedef struct packed {
        logic [CFG_W-1:0] debounce;
        logic [CFG_W-1:0] long_push;
        logic [CFG_W-1:0] prescale;
        logic [CFG_W-1:0] blink_half;
    } stw_cfg_t;

    // button events of one tick
    typedef struct packed {
        logic [NUM_BUTTONS-1:0] click;
        logic [NUM_BUTTONS-1:0] long_push;
    } stw_events_t;

    // what the control hands to the result register
    typedef struct packed {
        logic             scan;
        logic             blank;
        logic [SEL_W-1:0] select;
        logic [BCD_W-1:0] digit;
        logic             dot;
        logic [LED_W-1:0] leds;
        mode_t            mode;
        logic             running;
    } stw_view_t;

    // active-low seven-segment code, hex digits above nine
    function automatic logic [SEG_W-1:0] seg_code(input logic [BCD_W-1:0] d);
        logic [SEG_W-1:0] code;
        unique case (d)
            4'h0: code = 8'hC0;
            4'h1: code = 8'hF9;
            4'h2: code = 8'hA4;
            4'h3: code = 8'hB0;
            4'h4: code = 8'h99;
            4'h5: code = 8'h92;
            4'h6: code = 8'h82;
            4'h7: code = 8'hF8;
            4'h8: code = 8'h80;
            4'h9: code = 8'h90;
            4'hA: code = 8'h88;
            4'hB: code = 8'h83;
            4'hC: code = 8'hCA;
            4'hD: code = 8'hE1;
            4'hE: code = 8'h86;
            default: code = 8'h8E;
        endcase
        return code;
    endfunction

endpackage

@@ hdl/stw_debounce.sv @@
// per-button debounce turning raw levels into click and long-push events
module stw_debounce (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step,
    input  logic [stw_pkg::NUM_BUTTONS-1:0] levels,
    input  stw_pkg::stw_cfg_t               cfg,
    output stw_pkg::stw_events_t            events
);
    import stw_pkg::*;

    logic [CFG_W-1:0] count_reg [NUM_BUTTONS];
    logic [CFG_W-1:0] count_next [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] det_reg, det_next;
    logic [NUM_BUTTONS-1:0] down_reg, down_next;
    logic [NUM_BUTTONS-1:0] long_reg, long_next;

    // one lane per button
    always_comb
    begin
        logic [CFG_W-1:0] cnt;
        cnt = '0;
        events = '0;
        for (int b = 0; b < NUM_BUTTONS; b++)
        begin
            count_next[b] = count_reg[b];
            det_next[b]   = det_reg[b];
            down_next[b]  = down_reg[b];
            long_next[b]  = long_reg[b];
            cnt = (count_reg[b] == COUNT_MAX) ? count_reg[b] : count_reg[b] + 1'b1;
            if (!levels[b])
            begin
                if (!long_reg[b])
                begin
                    count_next[b] = cnt;
                    det_next[b]   = 1'b1;
                    if (down_reg[b])
                    begin
                        if (cnt >= cfg.long_push)
                        begin
                            long_next[b] = 1'b1;
                            events.long_push[b] = 1'b1;
                        end
                    end
                    else if (cnt >= cfg.debounce)
                    begin
                        down_next[b] = 1'b1;
                    end
                end
            end
            else if (det_reg[b])
            begin
                events.click[b] = down_reg[b] && !long_reg[b];
                count_next[b] = '0;
                det_next[b]   = 1'b0;
                down_next[b]  = 1'b0;
                long_next[b]  = 1'b0;
            end
        end
        if (!step)
        begin
            events = '0;
        end
    end

    // press state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < NUM_BUTTONS; b++)
            begin
                count_reg[b] <= '0;
            end
            det_reg  <= '0;
            down_reg <= '0;
            long_reg <= '0;
        end
        else if (step)
        begin
            for (int b = 0; b < NUM_BUTTONS; b++)
            begin
                count_reg[b] <= count_next[b];
            end
            det_reg  <= det_next;
            down_reg <= down_next;
            long_reg <= long_next;
        end
    end

endmodule

@@ hdl/stw_control.sv @@
// blink, scan, mode rules and bcd counter state, updated once per tick
module stw_control #(
    parameter int NUM_DIGITS  = stw_pkg::DEF_NUM_DIGITS,
    parameter int NUM_RECORDS = stw_pkg::DEF_NUM_RECORDS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  stw_pkg::stw_cfg_t    cfg,
    input  stw_pkg::stw_events_t events,
    output stw_pkg::stw_view_t   view
);
    import stw_pkg::*;

    localparam int DIG_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int REC_W = $clog2(NUM_RECORDS);
    localparam logic [DIG_W-1:0] LAST_DIGIT  = DIG_W'(NUM_DIGITS - 1);
    localparam logic [REC_W-1:0] LAST_RECORD = REC_W'(NUM_RECORDS - 1);
    localparam logic [7:0]       SCAN_FIRST  = 8'(1 << (NUM_DIGITS - 1));
    localparam int               DOT_POSITION = 1;

    mode_t            mode_reg, mode_next;
    logic             run_reg, run_next;
    logic             rev_reg, rev_next;
    logic             hide_reg, hide_next;
    logic [CFG_W-1:0] blink_reg, blink_next;
    logic [CFG_W-1:0] prescale_reg, prescale_next;
    logic [DIG_W-1:0] scan_reg, scan_next;
    logic [DIG_W-1:0] edit_reg, edit_next;
    logic [REC_W-1:0] rec_reg, rec_next;
    logic [BCD_W-1:0]   digit_reg [NUM_DIGITS];
    logic [BCD_W-1:0]   digit_next [NUM_DIGITS];
    logic [FLASH_W-1:0] flash_reg [NUM_DIGITS];
    logic [FLASH_W-1:0] flash_next [NUM_DIGITS];

    function automatic logic [REC_W-1:0] rec_fwd(input logic [REC_W-1:0] r);
        return (r == LAST_RECORD) ? '0 : r + 1'b1;
    endfunction

    function automatic logic [REC_W-1:0] rec_back(input logic [REC_W-1:0] r);
        return (r == '0) ? LAST_RECORD : r - 1'b1;
    endfunction

    // blink timer and digit scan, then button rules, then the counter
    always_comb
    begin
        logic [CFG_W-1:0] blink_inc;
        logic             toggle;
        logic             carry;
        logic [CFG_W:0]   pre_sum;
        logic [7:0]       sel_hot;
        blink_inc = blink_reg + 1'b1;
        view = '0;
        view.scan = (blink_inc[1:0] == 2'b00);
        toggle = view.scan && ((blink_inc == '0) || (blink_inc >= cfg.blink_half));
        hide_next  = toggle ? ~hide_reg : hide_reg;
        blink_next = toggle ? '0 : blink_inc;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            flash_next[i] = flash_reg[i];
            if (toggle && !hide_next && (flash_reg[i] != '0)
                && (flash_reg[i] != FLASH_FOREVER))
            begin
                flash_next[i] = flash_reg[i] - 1'b1;
            end
            digit_next[i] = digit_reg[i];
        end

        // digit shown on this scan
        sel_hot = SCAN_FIRST >> scan_reg;
        view.blank  = hide_next && (flash_next[scan_reg] != '0);
        view.select = ~sel_hot[SEL_W-1:0];
        view.digit  = digit_reg[scan_reg];
        view.dot    = (int'(scan_reg) != DOT_POSITION);
        scan_next   = view.scan ? ((scan_reg == LAST_DIGIT) ? '0 : scan_reg + 1'b1)
                                : scan_reg;

        // button rules in button order
        mode_next = mode_reg;
        run_next  = run_reg;
        rev_next  = rev_reg;
        edit_next = edit_reg;
        rec_next  = rec_reg;
        for (int b = 0; b < NUM_BUTTONS; b++)
        begin
            if (events.click[b])
            begin
                case (b)
                    BTN_RUN:
                    begin
                        if (mode_next != MODE_TIMING)
                            mode_next = MODE_TIMING;
                        else
                            run_next = ~run_next;
                    end
                    BTN_CLEAR:
                    begin
                        if (mode_next == MODE_TIMING || mode_next == MODE_SETTING)
                            for (int i = 0; i < NUM_DIGITS; i++)
                                digit_next[i] = '0;
                    end
                    BTN_UP:
                    begin
                        if (mode_next == MODE_TIMING)
                            rec_next = rec_fwd(rec_next);
                        else if (mode_next == MODE_VIEW)
                            rec_next = rec_back(rec_next);
                        else if (mode_next == MODE_SETTING)
                            for (int i = 0; i < NUM_DIGITS; i++)
                                if (DIG_W'(i) == edit_next)
                                    digit_next[i] = (digit_next[i] >= BCD_NINE) ? '0
                                                    : digit_next[i] + 1'b1;
                    end
                    default:
                    begin
                        if (mode_next == MODE_TIMING)
                            rec_next = rec_fwd(rec_next);
                        else if (mode_next == MODE_SETTING)
                            for (int i = 0; i < NUM_DIGITS; i++)
                                if (DIG_W'(i) == edit_next)
                                    digit_next[i] = (digit_next[i] == '0) ? BCD_NINE
                                                    : digit_next[i] - 1'b1;
                    end
                endcase
            end
            if (events.long_push[b])
            begin
                case (b)
                    BTN_RUN:
                    begin
                        if (mode_next == MODE_TIMING)
                        begin
                            mode_next  = MODE_SETTING;
                            run_next   = 1'b0;
                            edit_next  = '0;
                            for (int i = 0; i < NUM_DIGITS; i++)
                                flash_next[i] = (i == 0) ? FLASH_FOREVER : '0;
                            hide_next  = 1'b1;
                            blink_next = '0;
                        end
                    end
                    BTN_CLEAR:
                    begin
                        if (mode_next == MODE_TIMING)
                        begin
                            rev_next = ~rev_next;
                            for (int i = 0; i < NUM_DIGITS; i++)
                                flash_next[i] = FLASH_ONCE;
                            hide_next  = 1'b1;
                            blink_next = '0;
                        end
                    end
                    BTN_UP:
                    begin
                        if (mode_next == MODE_TIMING)
                            mode_next = MODE_VIEW;
                        else if (mode_next == MODE_SETTING)
                        begin
                            edit_next = (edit_next == LAST_DIGIT) ? '0 : edit_next + 1'b1;
                            for (int i = 0; i < NUM_DIGITS; i++)
                                flash_next[i] = (DIG_W'(i) == edit_next) ? FLASH_FOREVER
                                                                          : '0;
                        end
                    end
                    default:
                    begin
                        if (mode_next == MODE_SETTING)
                        begin
                            edit_next = (edit_next == '0) ? LAST_DIGIT : edit_next - 1'b1;
                            for (int i = 0; i < NUM_DIGITS; i++)
                                flash_next[i] = (DIG_W'(i) == edit_next) ? FLASH_FOREVER
                                                                          : '0;
                        end
                    end
                endcase
            end
        end

        // prescaled bcd step with ripple carry or borrow
        prescale_next = prescale_reg;
        pre_sum = {1'b0, prescale_reg} + 1'b1;
        carry = 1'b0;
        if (run_next)
        begin
            if (pre_sum >= {1'b0, cfg.prescale})
            begin
                prescale_next = '0;
                carry = 1'b1;
            end
            else
            begin
                prescale_next = pre_sum[CFG_W-1:0];
            end
        end
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (carry)
            begin
                if (rev_next)
                begin
                    if (digit_next[i] != '0)
                    begin
                        digit_next[i] = digit_next[i] - 1'b1;
                        carry = 1'b0;
                    end
                    else
                    begin
                        digit_next[i] = BCD_NINE;
                    end
                end
                else if (digit_next[i] < BCD_NINE)
                begin
                    digit_next[i] = digit_next[i] + 1'b1;
                    carry = 1'b0;
                end
                else
                begin
                    digit_next[i] = '0;
                end
            end
        end

        // status after the tick
        view.leds    = ~(LED_W'(1) << rec_next);
        view.mode    = mode_next;
        view.running = run_next;
    end

    // tick state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_TIMING;
            run_reg      <= 1'b1;
            rev_reg      <= 1'b0;
            hide_reg     <= 1'b0;
            blink_reg    <= '0;
            prescale_reg <= '0;
            scan_reg     <= '0;
            edit_reg     <= '0;
            rec_reg      <= '0;
            for (int i = 0; i < NUM_DIGITS; i++)
            begin
                digit_reg[i] <= '0;
                flash_reg[i] <= '0;
            end
        end
        else if (step)
        begin
            mode_reg     <= mode_next;
            run_reg      <= run_next;
            rev_reg      <= rev_next;
            hide_reg     <= hide_next;
            blink_reg    <= blink_next;
            prescale_reg <= prescale_next;
            scan_reg     <= scan_next;
            edit_reg     <= edit_next;
            rec_reg      <= rec_next;
            for (int i = 0; i < NUM_DIGITS; i++)
            begin
                digit_reg[i] <= digit_next[i];
                flash_reg[i] <= flash_next[i];
            end
        end
    end

endmodule

@@ hdl/stw_display.sv @@
// result register: display latch with segment decode and status outputs
module stw_display (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  stw_pkg::stw_view_t         view,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic [stw_pkg::SEL_W-1:0]  digit_select,
    output logic [stw_pkg::SEG_W-1:0]  segments,
    output logic                       decimal_point,
    output logic [stw_pkg::LED_W-1:0]  record_leds,
    output logic [1:0]                 mode_now,
    output logic                       running_now
);
    import stw_pkg::*;

    logic             valid_reg, valid_next;
    logic [SEL_W-1:0] select_reg, select_next;
    logic [SEG_W-1:0] seg_reg, seg_next;
    logic             dot_reg, dot_next;
    logic [LED_W-1:0] leds_reg;
    mode_t            mode_reg;
    logic             run_reg;

    // display latch holds between scans, blanking only drops the select
    always_comb
    begin
        select_next = select_reg;
        seg_next    = seg_reg;
        dot_next    = dot_reg;
        if (view.scan)
        begin
            if (view.blank)
            begin
                select_next = SELECT_BLANK;
            end
            else
            begin
                select_next = view.select;
                seg_next    = seg_code(view.digit);
                dot_next    = view.dot;
            end
        end
        valid_next = step ? 1'b1 : (out_ready ? 1'b0 : valid_reg);
    end

    // display and handshake state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            select_reg <= SELECT_BLANK;
            seg_reg    <= SEGMENTS_OFF;
            dot_reg    <= 1'b1;
        end
        else
        begin
            valid_reg <= valid_next;
            if (step)
            begin
                select_reg <= select_next;
                seg_reg    <= seg_next;
                dot_reg    <= dot_next;
            end
        end
    end

    // status payload
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            leds_reg <= view.leds;
            mode_reg <= view.mode;
            run_reg  <= view.running;
        end
    end

    assign out_valid     = valid_reg;
    assign digit_select  = select_reg;
    assign segments      = seg_reg;
    assign decimal_point = dot_reg;
    assign record_leds   = leds_reg;
    assign mode_now      = mode_reg;
    assign running_now   = run_reg;

endmodule

@@ hdl/stopwatch_button_display_controller_core.sv @@
// Stopwatch controller top level: one request is one 1 ms tick carrying the
// four raw active-low button levels, and each tick gives one result with the
// multiplexed seven-segment drive, the record LED and the mode and run status.
// A tick passes an input register, combinational control logic (blink timer,
// digit scan, debounce, mode rules, BCD count) and the result register, and a
// new request is taken every cycle while the result register is free or being
// emptied; a stalled receiver holds the flow. Configuration writes go straight
// into the four 10-bit registers and should be made while no tick is in flight.
module stopwatch_button_display_controller_core #(
    parameter int NUM_DIGITS  = stw_pkg::DEF_NUM_DIGITS,
    parameter int NUM_RECORDS = stw_pkg::DEF_NUM_RECORDS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [1:0]                      cfg_index,
    input  logic [stw_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [stw_pkg::NUM_BUTTONS-1:0] button_levels,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [stw_pkg::SEL_W-1:0]       digit_select,
    output logic [stw_pkg::SEG_W-1:0]       segments,
    output logic                            decimal_point,
    output logic [stw_pkg::LED_W-1:0]       record_leds,
    output logic [1:0]                      mode_now,
    output logic                            running_now
);
    import stw_pkg::*;

    stw_cfg_t               cfg_reg;
    logic                   in_valid_reg;
    logic [NUM_BUTTONS-1:0] levels_reg;
    logic                   step;
    stw_events_t            events;
    stw_view_t              view;

    // a tick moves on when the result register is free or being emptied
    assign step     = in_valid_reg && (!out_valid || out_ready);
    assign in_ready = !in_valid_reg || step;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce   <= DEBOUNCE_RESET;
            cfg_reg.long_push  <= LONG_PUSH_RESET;
            cfg_reg.prescale   <= PRESCALE_RESET;
            cfg_reg.blink_half <= BLINK_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_DEBOUNCE:  cfg_reg.debounce   <= cfg_data;
                CFG_LONG_PUSH: cfg_reg.long_push  <= cfg_data;
                CFG_PRESCALE:  cfg_reg.prescale   <= cfg_data;
                CFG_BLINK:     cfg_reg.blink_half <= cfg_data;
                default:       cfg_reg.debounce   <= cfg_reg.debounce;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            levels_reg <= button_levels;
        end
    end

    stw_debounce u_debounce (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .levels (levels_reg),
        .cfg    (cfg_reg),
        .events (events)
    );

    stw_control #(
        .NUM_DIGITS  (NUM_DIGITS),
        .NUM_RECORDS (NUM_RECORDS)
    ) u_control (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .cfg    (cfg_reg),
        .events (events),
        .view   (view)
    );

    stw_display u_display (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .view          (view),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .digit_select  (digit_select),
        .segments      (segments),
        .decimal_point (decimal_point),
        .record_leds   (record_leds),
        .mode_now      (mode_now),
        .running_now   (running_now)
    );

endmodule

@@ tb/sv/testbench.sv @@
// testbench of the stopwatch controller core: button tick requests checked against a tick model
`timescale 1ns / 100ps

module testbench;
    import stw_pkg::*;

    localparam int DIGITS          = DEF_NUM_DIGITS;
    localparam int RECORDS         = DEF_NUM_RECORDS;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int DRAIN_CYCLES    = 6;

    localparam logic [NUM_BUTTONS-1:0] ALL_RELEASED = '1;
    localparam logic [NUM_BUTTONS-1:0] KEY_RUN      = NUM_BUTTONS'(1) << BTN_RUN;
    localparam logic [NUM_BUTTONS-1:0] KEY_CLEAR    = NUM_BUTTONS'(1) << BTN_CLEAR;
    localparam logic [NUM_BUTTONS-1:0] KEY_UP       = NUM_BUTTONS'(1) << BTN_UP;
    localparam logic [NUM_BUTTONS-1:0] KEY_DOWN     = NUM_BUTTONS'(1) << BTN_DOWN;
    localparam logic [NUM_BUTTONS-1:0] KEY_ALL      = '1;

    // active-low glyphs, hex letters above nine
    localparam logic [SEG_W-1:0] GLYPHS [16] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8,
        8'h80, 8'h90, 8'h88, 8'h83, 8'hCA, 8'hE1, 8'h86, 8'h8E
    };

    // what one tick puts on the outputs
    typedef struct packed {
        logic [SEL_W-1:0] select;
        logic [SEG_W-1:0] segs;
        logic             dot;
        logic [LED_W-1:0] leds;
        logic [1:0]       mode;
        logic             running;
    } frame_t;

    // block ports
    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_write     = 1'b0;
    logic [1:0]             cfg_index     = CFG_DEBOUNCE;
    logic [CFG_W-1:0]       cfg_data      = '0;
    logic                   in_valid      = 1'b0;
    logic                   in_ready;
    logic [NUM_BUTTONS-1:0] button_levels = ALL_RELEASED;
    logic                   out_valid;
    logic                   out_ready     = 1'b0;
    logic [SEL_W-1:0]       digit_select;
    logic [SEG_W-1:0]       segments;
    logic                   decimal_point;
    logic [LED_W-1:0]       record_leds;
    logic [1:0]             mode_now;
    logic                   running_now;

    // stimulus and scoreboard
    logic [NUM_BUTTONS-1:0] button_script [$];
    frame_t                 expected_frames [$];
    frame_t                 oldest_frame;
    frame_t                 new_frame;
    int                     ticks_queued      = 0;
    int                     ticks_taken       = 0;
    int                     mismatches        = 0;
    bit                     req_taken         = 1'b0;
    int                     sender_idle_pct   = 24;
    int                     receiver_idle_pct = 57;
    int                     hold_requests     = 0;
    int                     holds_done        = 0;
    int                     hold_left         = 0;
    int                     stim_deb          = int'(DEBOUNCE_RESET);
    int                     stim_long         = int'(LONG_PUSH_RESET);

    // stopwatch model state
    stw_cfg_t           model_cfg;
    mode_t              mode_q;
    logic               run_q;
    logic               rev_q;
    logic               hide_q;
    logic [BCD_W-1:0]   digits_q [DIGITS];
    logic [FLASH_W-1:0] flash_q [DIGITS];
    int                 edit_pos;
    int                 rec_pos;
    int                 scan_pos;
    int                 prescale_cnt;
    logic [CFG_W-1:0]   blink_cnt;
    int                 press_cnt [NUM_BUTTONS];
    logic               det_q [NUM_BUTTONS];
    logic               down_q [NUM_BUTTONS];
    logic               long_q [NUM_BUTTONS];
    logic [SEL_W-1:0]   sel_q;
    logic [SEG_W-1:0]   seg_q;
    logic               dot_q;

    stopwatch_button_display_controller_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .button_levels (button_levels),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .digit_select  (digit_select),
        .segments      (segments),
        .decimal_point (decimal_point),
        .record_leds   (record_leds),
        .mode_now      (mode_now),
        .running_now   (running_now)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // flash one digit forever, stop the rest
    task automatic flash_single(input int pos);
        for (int i = 0; i < DIGITS; i++)
            flash_q[i] = (i == pos) ? FLASH_FOREVER : '0;
    endtask

    // mode rules for a short press
    task automatic apply_click(input int b);
        case (b)
            BTN_RUN:
                if (mode_q != MODE_TIMING)
                    mode_q = MODE_TIMING;
                else
                    run_q = !run_q;
            BTN_CLEAR:
                if (mode_q == MODE_TIMING || mode_q == MODE_SETTING)
                    for (int i = 0; i < DIGITS; i++)
                        digits_q[i] = '0;
            BTN_UP:
                if (mode_q == MODE_TIMING)
                    rec_pos = (rec_pos + 1) % RECORDS;
                else if (mode_q == MODE_SETTING)
                    digits_q[edit_pos] = (digits_q[edit_pos] >= BCD_NINE) ? '0
                                                                          : digits_q[edit_pos] + 1'b1;
                else if (mode_q == MODE_VIEW)
                    rec_pos = (rec_pos + RECORDS - 1) % RECORDS;
            default:
                if (mode_q == MODE_TIMING)
                    rec_pos = (rec_pos + 1) % RECORDS;
                else if (mode_q == MODE_SETTING)
                    digits_q[edit_pos] = (digits_q[edit_pos] == '0) ? BCD_NINE
                                                                    : digits_q[edit_pos] - 1'b1;
        endcase
    endtask

    // mode rules for a long push
    task automatic apply_long(input int b);
        case (b)
            BTN_RUN:
                if (mode_q == MODE_TIMING)
                begin
                    mode_q    = MODE_SETTING;
                    run_q     = 1'b0;
                    edit_pos  = 0;
                    flash_single(0);
                    hide_q    = 1'b1;
                    blink_cnt = '0;
                end
            BTN_CLEAR:
                if (mode_q == MODE_TIMING)
                begin
                    rev_q = !rev_q;
                    for (int i = 0; i < DIGITS; i++)
                        flash_q[i] = FLASH_ONCE;
                    hide_q    = 1'b1;
                    blink_cnt = '0;
                end
            BTN_UP:
                if (mode_q == MODE_TIMING)
                    mode_q = MODE_VIEW;
                else if (mode_q == MODE_SETTING)
                begin
                    edit_pos = (edit_pos + 1) % DIGITS;
                    flash_single(edit_pos);
                end
            default:
                if (mode_q == MODE_SETTING)
                begin
                    edit_pos = (edit_pos + DIGITS - 1) % DIGITS;
                    flash_single(edit_pos);
                end
        endcase
    endtask

    // one 1 ms tick of the stopwatch: blink and scan, debounce, count
    task automatic advance_stopwatch(input logic [NUM_BUTTONS-1:0] levels, output frame_t f);
        logic wrapped;
        logic carry;
        // blink timer, a scan every fourth tick
        blink_cnt = blink_cnt + 1'b1;
        wrapped   = (blink_cnt == '0);
        if (blink_cnt[1:0] == 2'd0)
        begin
            if (wrapped || blink_cnt >= model_cfg.blink_half)
            begin
                hide_q = !hide_q;
                if (!hide_q)
                    for (int i = 0; i < DIGITS; i++)
                        if (flash_q[i] != '0 && flash_q[i] != FLASH_FOREVER)
                            flash_q[i] = flash_q[i] - 1'b1;
                blink_cnt = '0;
            end
            if (hide_q && flash_q[scan_pos] != '0)
                sel_q = SELECT_BLANK;
            else
            begin
                sel_q = ~(4'b1000 >> scan_pos);
                seg_q = GLYPHS[digits_q[scan_pos]];
                dot_q = (scan_pos != 1);
            end
            scan_pos = (scan_pos + 1) % DIGITS;
        end
        // debounce, buttons in order
        for (int b = 0; b < NUM_BUTTONS; b++)
        begin
            if (!levels[b])
            begin
                if (!long_q[b])
                begin
                    if (press_cnt[b] < COUNT_MAX)
                        press_cnt[b]++;
                    det_q[b] = 1'b1;
                    if (down_q[b])
                    begin
                        if (press_cnt[b] >= model_cfg.long_push)
                        begin
                            long_q[b] = 1'b1;
                            apply_long(b);
                        end
                    end
                    else if (press_cnt[b] >= model_cfg.debounce)
                        down_q[b] = 1'b1;
                end
            end
            else if (det_q[b])
            begin
                if (down_q[b] && !long_q[b])
                    apply_click(b);
                det_q[b]     = 1'b0;
                down_q[b]    = 1'b0;
                long_q[b]    = 1'b0;
                press_cnt[b] = 0;
            end
        end
        // bcd counter with ripple carry or borrow
        if (run_q)
        begin
            prescale_cnt++;
            if (prescale_cnt >= model_cfg.prescale)
            begin
                prescale_cnt = 0;
                carry        = 1'b1;
                for (int i = 0; i < DIGITS; i++)
                    if (carry)
                    begin
                        if (rev_q)
                        begin
                            if (digits_q[i] != '0)
                            begin
                                digits_q[i] = digits_q[i] - 1'b1;
                                carry       = 1'b0;
                            end
                            else
                                digits_q[i] = BCD_NINE;
                        end
                        else if (digits_q[i] < BCD_NINE)
                        begin
                            digits_q[i] = digits_q[i] + 1'b1;
                            carry       = 1'b0;
                        end
                        else
                            digits_q[i] = '0;
                    end
            end
        end
        f.select  = sel_q;
        f.segs    = seg_q;
        f.dot     = dot_q;
        f.leds    = ~(LED_W'(1) << rec_pos);
        f.mode    = mode_q;
        f.running = run_q;
    endtask

    // report one differing field
    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // scoreboard: check results, follow register writes, model accepted requests
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // result taken at this edge against the oldest prediction
            if (out_valid && out_ready)
            begin
                if (expected_frames.size() == 0)
                begin
                    $display("%0t: result with no request outstanding, select %0h segments %0h",
                             $time, digit_select, segments);
                    mismatches++;
                end
                else
                begin
                    oldest_frame = expected_frames.pop_front();
                    check_field("digit_select", 32'(oldest_frame.select), 32'(digit_select));
                    check_field("segments", 32'(oldest_frame.segs), 32'(segments));
                    check_field("decimal_point", 32'(oldest_frame.dot), 32'(decimal_point));
                    check_field("record_leds", 32'(oldest_frame.leds), 32'(record_leds));
                    check_field("mode_now", 32'(oldest_frame.mode), 32'(mode_now));
                    check_field("running_now", 32'(oldest_frame.running), 32'(running_now));
                end
            end
            // register writes
            if (cfg_write)
                case (cfg_index_t'(cfg_index))
                    CFG_DEBOUNCE:  model_cfg.debounce   = cfg_data;
                    CFG_LONG_PUSH: model_cfg.long_push  = cfg_data;
                    CFG_PRESCALE:  model_cfg.prescale   = cfg_data;
                    default:       model_cfg.blink_half = cfg_data;
                endcase
            // tick request taken at this edge
            req_taken = in_valid && in_ready;
            if (req_taken)
            begin
                advance_stopwatch(button_levels, new_frame);
                expected_frames.push_back(new_frame);
                ticks_taken++;
            end
        end
    end

    // request driver: valid held until taken
    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && !req_taken))
        begin
            if (button_script.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                in_valid      <= 1'b1;
                button_levels <= button_script.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result receiver with random stalls and a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_requests != holds_done)
        begin
            holds_done = hold_requests;
            hold_left  = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // one register write
    task automatic write_reg(input cfg_index_t idx, input int value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // full register set, also kept for shaping the presses
    task automatic configure(input int deb, input int lng, input int pre, input int blk);
        write_reg(CFG_DEBOUNCE, deb);
        write_reg(CFG_LONG_PUSH, lng);
        write_reg(CFG_PRESCALE, pre);
        write_reg(CFG_BLINK, blk);
        stim_deb  = deb;
        stim_long = lng;
    endtask

    task automatic queue_levels(input logic [NUM_BUTTONS-1:0] lv, input int n);
        repeat (n)
        begin
            button_script.push_back(lv);
            ticks_queued++;
        end
    endtask

    // press the buttons in mask for some ticks, then let go
    task automatic queue_press(input logic [NUM_BUTTONS-1:0] mask, input int hold,
                               input int gap);
        queue_levels(~mask, hold);
        queue_levels(ALL_RELEASED, gap);
    endtask

    // mostly clean presses around the debounce and long-push limits, some noise
    task automatic queue_random(input int count);
        int                     start;
        int                     kind;
        int                     hold;
        int                     first_long;
        logic [NUM_BUTTONS-1:0] mask;
        start      = ticks_queued;
        first_long = (stim_deb + 1 > stim_long) ? stim_deb + 1 : stim_long;
        while (ticks_queued - start < count)
        begin
            kind = $urandom_range(99);
            if (kind < 70)
            begin
                if ($urandom_range(9) == 0)
                    mask = NUM_BUTTONS'($urandom_range(15));
                else
                    mask = NUM_BUTTONS'(1) << $urandom_range(NUM_BUTTONS - 1);
                case ($urandom_range(3))
                    0:       hold = $urandom_range(stim_deb, 1);
                    1, 2:    hold = $urandom_range(first_long - 1, stim_deb);
                    default: hold = $urandom_range(first_long + 2, first_long);
                endcase
                queue_press(mask, hold, $urandom_range(3, 1));
            end
            else if (kind < 85)
                queue_levels(ALL_RELEASED, $urandom_range(8, 1));
            else
                repeat ($urandom_range(4, 1))
                    queue_levels(NUM_BUTTONS'($urandom_range(15)), 1);
        end
    endtask

    // wait until every tick has been answered, then let the pipeline settle
    task automatic wait_drained;
        while (ticks_taken != ticks_queued || expected_frames.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // run sequence
    initial
    begin
        // model state after reset
        model_cfg.debounce   = DEBOUNCE_RESET;
        model_cfg.long_push  = LONG_PUSH_RESET;
        model_cfg.prescale   = PRESCALE_RESET;
        model_cfg.blink_half = BLINK_RESET;
        mode_q       = MODE_TIMING;
        run_q        = 1'b1;
        rev_q        = 1'b0;
        hide_q       = 1'b0;
        edit_pos     = 0;
        rec_pos      = 0;
        scan_pos     = 0;
        prescale_cnt = 0;
        blink_cnt    = '0;
        sel_q        = SELECT_BLANK;
        seg_q        = SEGMENTS_OFF;
        dot_q        = 1'b1;
        for (int i = 0; i < DIGITS; i++)
        begin
            digits_q[i] = '0;
            flash_q[i]  = '0;
        end
        for (int b = 0; b < NUM_BUTTONS; b++)
        begin
            press_cnt[b] = 0;
            det_q[b]     = 1'b0;
            down_q[b]    = 1'b0;
            long_q[b]    = 1'b0;
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset register values: all four buttons clicked together
        queue_press(KEY_ALL, 10, 1);
        wait_drained;

        // every action with the shortest press limits
        configure(1, 2, 1, 4);
        queue_press(KEY_ALL, 1, 1);
        queue_press(KEY_CLEAR, 2, 1);
        queue_press(KEY_RUN, 2, 1);
        queue_press(KEY_UP, 1, 1);
        queue_press(KEY_DOWN, 1, 1);
        queue_press(KEY_UP, 2, 1);
        queue_press(KEY_DOWN, 2, 1);
        queue_press(KEY_CLEAR, 1, 1);
        queue_press(KEY_RUN, 1, 1);
        queue_press(KEY_UP, 2, 1);
        queue_press(KEY_UP | KEY_CLEAR | KEY_DOWN, 1, 1);
        queue_press(KEY_RUN, 1, 1);
        wait_drained;

        // random presses, with a long receiver hold-off to back the block up
        configure(2, 6, 3, 8);
        queue_random(100);
        while (button_script.size() > 70)
            @(negedge clk);
        hold_requests++;
        wait_drained;

        // idling swapped, the sender pausing for a full drain halfway
        sender_idle_pct   = 57;
        receiver_idle_pct = 24;
        configure(3, 9, 2, 12);
        queue_random(50);
        wait_drained;
        queue_random(50);
        wait_drained;

        // top register values: a press held well short of the limits
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        configure(int'(COUNT_MAX), int'(COUNT_MAX), int'(COUNT_MAX), int'(COUNT_MAX));
        queue_levels(ALL_RELEASED, 2);
        queue_press(KEY_UP, 40, 8);
        wait_drained;

        // lowest limits, prescale lowered below the running count
        configure(1, 1, 5, 4);
        queue_random(110);
        wait_drained;

        if (mismatches == 0 && expected_frames.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // run time limit
    initial
    begin
        #400000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
